// File: src/mflg_pkg.sv
package mflg_pkg;

  localparam int NODE_W  = 7;
  localparam int CAPIN_W = 20;
  localparam int FLOW_W  = 24;
  localparam int CIDX_W  = 2;

  localparam logic [FLOW_W-1:0] FLOW_CAP = 24'd10000000;

  localparam logic [CIDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SOURCE     = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SINK       = 2'd2;

  typedef enum logic [29:0] {
    S_CLR      = 30'h1 << 0,
    S_IDLE     = 30'h1 << 1,
    S_ADD_RD   = 30'h1 << 2,
    S_ADD_WR   = 30'h1 << 3,
    S_SOLVE    = 30'h1 << 4,
    S_BFS_INIT = 30'h1 << 5,
    S_BFS_POP  = 30'h1 << 6,
    S_BFS_U    = 30'h1 << 7,
    S_BFS_UL   = 30'h1 << 8,
    S_BFS_REQ  = 30'h1 << 9,
    S_BFS_CHK  = 30'h1 << 10,
    S_BFS_END  = 30'h1 << 11,
    S_P_CLR    = 30'h1 << 12,
    S_P_START  = 30'h1 << 13,
    S_P_TOP    = 30'h1 << 14,
    S_P_U      = 30'h1 << 15,
    S_P_ARC    = 30'h1 << 16,
    S_P_REQ    = 30'h1 << 17,
    S_P_CHK    = 30'h1 << 18,
    S_P_ADV    = 30'h1 << 19,
    S_P_END    = 30'h1 << 20,
    S_AUG_S    = 30'h1 << 21,
    S_AUG_A0   = 30'h1 << 22,
    S_AUG_CK   = 30'h1 << 23,
    S_AUG_B    = 30'h1 << 24,
    S_AUG_M    = 30'h1 << 25,
    S_AUG_W    = 30'h1 << 26,
    S_AUG_NX   = 30'h1 << 27,
    S_AUG_FIN  = 30'h1 << 28,
    S_EMIT     = 30'h1 << 29
  } state_t;

  typedef struct packed {
    state_t op;
    logic   load;
  } dp_cmd_t;

  typedef struct packed {
    logic st_same;
    logic st_ok;
    logic q_more;
    logic scan_last;
    logic t_reached;
    logic lim_hit;
    logic at_sink;
    logic v_end;
    logic hit;
    logic can_push;
    logic depth_zero;
    logic aug_end;
    logic pass;
    logic flow_more;
    logic clr_last;
  } dp_status_t;

endpackage

// File: src/max_flow_level_graph_engine_top.sv
// Channel    Ports                                              Handshake
// input      in_func, in_from_node, in_to_node, in_capacity     start & !busy
// result     out_max_flow                                       out_strobe, one cycle
// config     cfg_index, cfg_data                                cfg_we
// An edge word takes a read and a write of the capacity memory.
// Leveling pops each node and reads its level, then requests and checks each pair.
// A path step reads the stack top and its arc, then requests and checks arcs until
// a hit or a dead end; an augmenting path finds the bottleneck, then updates edges.
// The result strobe is registered from the emit state; the clearing pass then
// writes 4^ceil(log2(MAX_NODES)) capacity words, 4096 by default, and also runs after
// reset. Busy stays high throughout. The receiver cannot stall.
module max_flow_level_graph_engine_top import mflg_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int CAP_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [NODE_W-1:0]  in_from_node,
  input  logic [NODE_W-1:0]  in_to_node,
  input  logic [CAPIN_W-1:0] in_capacity,
  output logic               out_strobe,
  output logic [FLOW_W-1:0]  out_max_flow,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [NODE_W-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mflg_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .func   (in_func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mflg_dp #(
    .MAX_NODES (MAX_NODES),
    .CAP_WIDTH (CAP_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_from_node (in_from_node),
    .in_to_node   (in_to_node),
    .in_capacity  (in_capacity),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .status       (status),
    .out_strobe   (out_strobe),
    .out_max_flow (out_max_flow)
  );

endmodule

// File: src/mflg_ctrl.sv
module mflg_ctrl import mflg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       func,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:      state_nxt = status.clr_last ? S_IDLE : S_CLR;
      S_IDLE: begin
        if (start) begin
          state_nxt = func ? S_SOLVE : S_ADD_RD;
        end
      end
      S_ADD_RD:   state_nxt = S_ADD_WR;
      S_ADD_WR:   state_nxt = S_IDLE;
      S_SOLVE:    state_nxt = (status.st_same || !status.st_ok) ? S_EMIT : S_BFS_INIT;
      S_BFS_INIT: state_nxt = S_BFS_POP;
      S_BFS_POP:  state_nxt = status.q_more ? S_BFS_U : S_BFS_END;
      S_BFS_U:    state_nxt = S_BFS_UL;
      S_BFS_UL:   state_nxt = S_BFS_REQ;
      S_BFS_REQ:  state_nxt = S_BFS_CHK;
      S_BFS_CHK:  state_nxt = status.scan_last ? S_BFS_POP : S_BFS_REQ;
      S_BFS_END:  state_nxt = status.t_reached ? S_P_CLR : S_EMIT;
      S_P_CLR:    state_nxt = status.scan_last ? S_P_START : S_P_CLR;
      S_P_START:  state_nxt = S_P_TOP;
      S_P_TOP:    state_nxt = status.lim_hit ? S_P_END : S_P_U;
      S_P_U:      state_nxt = status.at_sink ? S_AUG_S : S_P_ARC;
      S_P_ARC:    state_nxt = S_P_REQ;
      S_P_REQ:    state_nxt = status.v_end ? S_P_ADV : S_P_CHK;
      S_P_CHK:    state_nxt = status.hit ? S_P_ADV : S_P_REQ;
      S_P_ADV: begin
        if (!status.can_push && status.depth_zero) begin
          state_nxt = S_P_END;
        end else begin
          state_nxt = S_P_TOP;
        end
      end
      S_P_END:    state_nxt = status.flow_more ? S_BFS_INIT : S_EMIT;
      S_AUG_S:    state_nxt = S_AUG_A0;
      S_AUG_A0:   state_nxt = S_AUG_CK;
      S_AUG_CK: begin
        if (status.aug_end) begin
          state_nxt = status.pass ? S_AUG_FIN : S_AUG_S;
        end else begin
          state_nxt = S_AUG_B;
        end
      end
      S_AUG_B:    state_nxt = S_AUG_M;
      S_AUG_M:    state_nxt = status.pass ? S_AUG_W : S_AUG_NX;
      S_AUG_W:    state_nxt = S_AUG_NX;
      S_AUG_NX:   state_nxt = S_AUG_CK;
      S_AUG_FIN:  state_nxt = S_P_TOP;
      S_EMIT:     state_nxt = S_CLR;
      default:    state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign cmd.op   = state_r;
  assign cmd.load = (state_r == S_IDLE) && start;

endmodule

// File: src/mflg_dp.sv
module mflg_dp import mflg_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int CAP_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [NODE_W-1:0]  in_from_node,
  input  logic [NODE_W-1:0]  in_to_node,
  input  logic [CAPIN_W-1:0] in_capacity,
  input  logic               cfg_we,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [NODE_W-1:0]  cfg_data,
  output dp_status_t         status,
  output logic               out_strobe,
  output logic [FLOW_W-1:0]  out_max_flow
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int XW  = (NCW > NODE_W) ? NCW : NODE_W;
  localparam int MW  = 2 * NW;
  localparam int CW  = CAP_WIDTH;
  localparam int SW  = ((CW > CAPIN_W) ? CW : CAPIN_W) + 1;
  localparam int BW  = (CW > FLOW_W) ? CW : FLOW_W;
  localparam logic [CW-1:0] CAP_MAX = {1'b0, {(CW-1){1'b1}}};

  logic [NODE_W-1:0]  node_count_r, src_r, snk_r;
  logic [NODE_W-1:0]  fr_r, fr_nxt, to_r, to_nxt;
  logic [CAPIN_W-1:0] cap_r, cap_nxt;
  logic [MW-1:0]      idx_r, idx_nxt;
  logic [NW-1:0]      u_r, u_nxt, a_r, a_nxt, b_r, b_nxt, i_r, i_nxt, depth_r, depth_nxt;
  logic [NCW-1:0]     v_r, v_nxt, lu_r, lu_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [FLOW_W-1:0]  total_r, total_nxt, ptotal_r, ptotal_nxt;
  logic [FLOW_W-1:0]  limit_r, limit_nxt, bn_r, bn_nxt;
  logic               pass_r, pass_nxt;
  logic [MAX_NODES-1:0] lvalid_r, lvalid_nxt;
  logic               out_strobe_r;
  logic [FLOW_W-1:0]  out_flow_r;

  logic [CW-1:0]  mat_mem [0:(1<<MW)-1];
  logic [NCW-1:0] lvl_mem [0:MAX_NODES-1];
  logic [NW-1:0]  q_mem   [0:MAX_NODES-1];
  logic [NW-1:0]  stk_mem [0:MAX_NODES-1];
  logic [NCW-1:0] arc_mem [0:MAX_NODES-1];

  logic [CW-1:0]  mat_rd_r;
  logic [NCW-1:0] lvl_rd_r;
  logic [NW-1:0]  q_rd_r;
  logic [NW-1:0]  stk_rd_r;
  logic [NCW-1:0] arc_rd_r;

  logic           mat_we, lvl_we, q_we, stk_we, arc_we;
  logic [MW-1:0]  mat_wa, mat_ra;
  logic [CW-1:0]  mat_wd;
  logic [NW-1:0]  lvl_wa, lvl_ra, q_wa, q_ra, stk_wa, stk_ra, arc_wa, arc_ra;
  logic [NCW-1:0] lvl_wd, arc_wd;
  logic [NW-1:0]  q_wd, stk_wd;

  logic [XW-1:0]  nc_x, n_x, s_x, t_x, fr_x, to_x;
  logic [NCW-1:0] n_eff;
  logic [NW-1:0]  s_idx, t_idx, fr_idx, to_idx, v_idx;
  logic           edge_ok, bfs_hit, p_hit;
  logic [SW-1:0]  add_sum;
  logic [CW-1:0]  add_sat;
  logic [FLOW_W:0] flow_sum;

  function automatic logic in_range(input logic [XW-1:0] x, input logic [NCW-1:0] n);
    in_range = (x != '0) && (x <= XW'(n));
  endfunction

  always_comb begin
    nc_x   = XW'(node_count_r);
    n_x    = (nc_x > XW'(MAX_NODES)) ? XW'(MAX_NODES) : nc_x;
    n_eff  = n_x[NCW-1:0];
    s_x    = XW'(src_r) - XW'(1);
    t_x    = XW'(snk_r) - XW'(1);
    fr_x   = XW'(fr_r) - XW'(1);
    to_x   = XW'(to_r) - XW'(1);
    s_idx  = s_x[NW-1:0];
    t_idx  = t_x[NW-1:0];
    fr_idx = fr_x[NW-1:0];
    to_idx = to_x[NW-1:0];
    v_idx  = v_r[NW-1:0];
    edge_ok = in_range(XW'(fr_r), n_eff) && in_range(XW'(to_r), n_eff);
    bfs_hit = !lvalid_r[v_idx] && (mat_rd_r != '0);
    p_hit   = lvalid_r[v_idx] && (lvl_rd_r == lu_r + NCW'(1)) && (mat_rd_r != '0);
    add_sum = SW'(mat_rd_r) + SW'(cap_r);
    add_sat = (add_sum > SW'(CAP_MAX)) ? CAP_MAX : add_sum[CW-1:0];
    flow_sum = {1'b0, total_r} + {1'b0, ptotal_r};
  end

  always_comb begin
    status.st_same    = (src_r == snk_r);
    status.st_ok      = in_range(XW'(src_r), n_eff) && in_range(XW'(snk_r), n_eff);
    status.q_more     = (head_r < tail_r);
    status.scan_last  = ((v_r + NCW'(1)) == n_eff);
    status.t_reached  = lvalid_r[t_idx];
    status.lim_hit    = (ptotal_r >= limit_r);
    status.at_sink    = (stk_rd_r == t_idx);
    status.v_end      = (v_r >= n_eff);
    status.hit        = p_hit;
    status.can_push   = (v_r < n_eff) && (depth_r != NW'(MAX_NODES - 1));
    status.depth_zero = (depth_r == '0);
    status.aug_end    = (i_r == depth_r);
    status.pass       = pass_r;
    status.flow_more  = (flow_sum < {1'b0, FLOW_CAP});
    status.clr_last   = &idx_r;
  end

  always_comb begin
    fr_nxt = fr_r;  to_nxt = to_r;  cap_nxt = cap_r;  idx_nxt = idx_r;
    u_nxt = u_r;  a_nxt = a_r;  b_nxt = b_r;  i_nxt = i_r;  depth_nxt = depth_r;
    v_nxt = v_r;  lu_nxt = lu_r;  head_nxt = head_r;  tail_nxt = tail_r;
    total_nxt = total_r;  ptotal_nxt = ptotal_r;  limit_nxt = limit_r;  bn_nxt = bn_r;
    pass_nxt = pass_r;  lvalid_nxt = lvalid_r;
    mat_we = 1'b0;  mat_wa = '0;  mat_wd = '0;  mat_ra = {u_r, v_idx};
    lvl_we = 1'b0;  lvl_wa = v_idx;  lvl_wd = lu_r + NCW'(1);  lvl_ra = v_idx;
    q_we = 1'b0;  q_wa = tail_r[NW-1:0];  q_wd = v_idx;  q_ra = head_r[NW-1:0];
    stk_we = 1'b0;  stk_wa = depth_r + NW'(1);  stk_wd = v_idx;  stk_ra = depth_r;
    arc_we = 1'b0;  arc_wa = u_r;  arc_wd = v_r;  arc_ra = stk_rd_r;

    if (cmd.load) begin
      fr_nxt  = in_from_node;
      to_nxt  = in_to_node;
      cap_nxt = in_capacity;
    end

    unique case (cmd.op)
      S_CLR: begin
        mat_we  = 1'b1;
        mat_wa  = idx_r;
        idx_nxt = idx_r + MW'(1);
      end
      S_ADD_RD: mat_ra = {fr_idx, to_idx};
      S_ADD_WR: begin
        mat_we = edge_ok;
        mat_wa = {fr_idx, to_idx};
        mat_wd = add_sat;
      end
      S_SOLVE: total_nxt = status.st_same ? FLOW_CAP : '0;
      S_BFS_INIT: begin
        lvalid_nxt        = '0;
        lvalid_nxt[s_idx] = 1'b1;
        lvl_we   = 1'b1;
        lvl_wa   = s_idx;
        lvl_wd   = '0;
        q_we     = 1'b1;
        q_wa     = '0;
        q_wd     = s_idx;
        head_nxt = '0;
        tail_nxt = NCW'(1);
      end
      S_BFS_POP: begin
        if (status.q_more) begin
          head_nxt = head_r + NCW'(1);
        end
      end
      S_BFS_U: begin
        u_nxt  = q_rd_r;
        lvl_ra = q_rd_r;
      end
      S_BFS_UL: begin
        lu_nxt = lvl_rd_r;
        v_nxt  = '0;
      end
      S_BFS_REQ: mat_ra = {u_r, v_idx};
      S_BFS_CHK: begin
        if (bfs_hit) begin
          lvalid_nxt[v_idx] = 1'b1;
          lvl_we   = 1'b1;
          q_we     = 1'b1;
          tail_nxt = tail_r + NCW'(1);
        end
        v_nxt = v_r + NCW'(1);
      end
      S_BFS_END: v_nxt = '0;
      S_P_CLR: begin
        arc_we = 1'b1;
        arc_wa = v_idx;
        arc_wd = '0;
        v_nxt  = v_r + NCW'(1);
      end
      S_P_START: begin
        stk_we     = 1'b1;
        stk_wa     = '0;
        stk_wd     = s_idx;
        depth_nxt  = '0;
        ptotal_nxt = '0;
        limit_nxt  = FLOW_CAP - total_r;
      end
      S_P_TOP: stk_ra = depth_r;
      S_P_U: begin
        u_nxt    = stk_rd_r;
        arc_ra   = stk_rd_r;
        lvl_ra   = stk_rd_r;
        bn_nxt   = limit_r - ptotal_r;
        pass_nxt = 1'b0;
      end
      S_P_ARC: begin
        v_nxt  = arc_rd_r;
        lu_nxt = lvl_rd_r;
      end
      S_P_REQ: begin
        mat_ra = {u_r, v_idx};
        lvl_ra = v_idx;
      end
      S_P_CHK: begin
        if (!p_hit) begin
          v_nxt = v_r + NCW'(1);
        end
      end
      S_P_ADV: begin
        arc_we = 1'b1;
        if (status.can_push) begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + NW'(1);
        end else begin
          lvalid_nxt[u_r] = 1'b0;
          if (depth_r != '0) begin
            depth_nxt = depth_r - NW'(1);
          end
        end
      end
      S_P_END: total_nxt = flow_sum[FLOW_W-1:0];
      S_AUG_S: begin
        stk_ra = '0;
        i_nxt  = '0;
      end
      S_AUG_A0: a_nxt = stk_rd_r;
      S_AUG_CK: begin
        stk_ra = i_r + NW'(1);
        if (status.aug_end && !pass_r) begin
          pass_nxt = 1'b1;
        end
      end
      S_AUG_B: begin
        b_nxt  = stk_rd_r;
        mat_ra = {a_r, stk_rd_r};
      end
      S_AUG_M: begin
        if (pass_r) begin
          mat_we = 1'b1;
          mat_wa = {a_r, b_r};
          mat_wd = mat_rd_r - CW'(bn_r);
          mat_ra = {b_r, a_r};
        end else if (BW'(mat_rd_r) < BW'(bn_r)) begin
          bn_nxt = FLOW_W'(mat_rd_r);
        end
      end
      S_AUG_W: begin
        mat_we = 1'b1;
        mat_wa = {b_r, a_r};
        mat_wd = mat_rd_r + CW'(bn_r);
      end
      S_AUG_NX: begin
        a_nxt = b_r;
        i_nxt = i_r + NW'(1);
      end
      S_AUG_FIN: begin
        ptotal_nxt = ptotal_r + bn_r;
        depth_nxt  = '0;
      end
      S_EMIT: idx_nxt = '0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(64);
      src_r        <= NODE_W'(1);
      snk_r        <= NODE_W'(2);
      idx_r        <= '0;
      total_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        priority case (cfg_index)
          REG_NODE_COUNT: node_count_r <= cfg_data;
          REG_SOURCE:     src_r        <= cfg_data;
          REG_SINK:       snk_r        <= cfg_data;
          default: begin
          end
        endcase
      end
      idx_r        <= idx_nxt;
      total_r      <= total_nxt;
      out_strobe_r <= (cmd.op == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    fr_r <= fr_nxt;  to_r <= to_nxt;  cap_r <= cap_nxt;
    u_r <= u_nxt;  a_r <= a_nxt;  b_r <= b_nxt;  i_r <= i_nxt;  depth_r <= depth_nxt;
    v_r <= v_nxt;  lu_r <= lu_nxt;  head_r <= head_nxt;  tail_r <= tail_nxt;
    ptotal_r <= ptotal_nxt;  limit_r <= limit_nxt;  bn_r <= bn_nxt;
    pass_r <= pass_nxt;  lvalid_r <= lvalid_nxt;
    out_flow_r <= total_r;
  end

  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= mat_wd;
    end
    mat_rd_r <= mat_mem[mat_ra];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_wa] <= lvl_wd;
    end
    lvl_rd_r <= lvl_mem[lvl_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    q_rd_r <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_r <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (arc_we) begin
      arc_mem[arc_wa] <= arc_wd;
    end
    arc_rd_r <= arc_mem[arc_ra];
  end

  assign out_strobe   = out_strobe_r;
  assign out_max_flow = out_flow_r;

endmodule
